/* hdl/lz77_window_decompressor_top_macros.svh */
// Assertion macros for the LZ77 window decompressor checker.
// Used by lz77wd_checker; needs i_clk and i_rst_n in scope.
`ifndef LZ77_WINDOW_DECOMPRESSOR_TOP_MACROS_SVH
`define LZ77_WINDOW_DECOMPRESSOR_TOP_MACROS_SVH

// Checked outside reset only.
`define LZWD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define LZWD_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

/* hdl/lz77wd_pkg.sv */
// Shared types and constants for the LZ77 window decompressor.
// No dependencies.
`default_nettype none

package lz77wd_pkg;

    localparam int LZWD_WINDOW_DEPTH = 4096;
    localparam int LZWD_QUEUE_DEPTH  = 4;
    localparam int LZWD_GROUP_SIZE   = 8;
    localparam int LZWD_MIN_MATCH    = 3;
    localparam int LZWD_DIST_W       = 13;   // distance 1..4096
    localparam int LZWD_CNT_W        = 5;    // byte count 1..18

    typedef enum logic [2:0] {
        PH_HDR0  = 3'd0,
        PH_HDR1  = 3'd1,
        PH_HDR2  = 3'd2,
        PH_HDR3  = 3'd3,
        PH_FLAG  = 3'd4,
        PH_TOKEN = 3'd5,
        PH_REF2  = 3'd6,
        PH_DONE  = 3'd7
    } t_phase;

    // One job for the back end: a literal or a window copy.
    typedef struct packed {
        logic                   is_lit;
        logic [7:0]             lit;
        logic [LZWD_DIST_W-1:0] offset;
        logic [LZWD_CNT_W-1:0]  cnt;
        logic                   eos;     // the job's final byte ends the stream
    } t_cmd;

endpackage

`default_nettype wire

/* hdl/lz77wd_front.sv */
// Stream parser: header, flag groups, tokens; turns them into copy jobs.
// Depends on lz77wd_pkg.
`default_nettype none

module lz77wd_front (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire logic [7:0]        i_byte,
    input  wire logic              i_sos,
    output logic                   o_push,
    output lz77wd_pkg::t_cmd       o_cmd,
    input  wire logic              i_full
);
    import lz77wd_pkg::*;

    t_phase      r_phase, n_phase;
    logic [23:0] r_len, n_len;
    logic [7:0]  r_flags, n_flags;
    logic [3:0]  r_tokens, n_tokens;
    logic [7:0]  r_ref_hi, n_ref_hi;

    logic                  acc;
    t_phase                ph;
    logic [23:0]           len;
    logic [23:0]           len_after;
    logic [3:0]            tok_dec;
    logic [LZWD_CNT_W-1:0] ref_cnt;
    logic [LZWD_CNT_W-1:0] take;
    logic                  tok_done;

    assign o_ready = !i_full;
    assign acc     = i_valid && !i_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HDR0;
            r_len    <= '0;
            r_flags  <= '0;
            r_tokens <= '0;
            r_ref_hi <= '0;
        end else begin
            r_phase  <= n_phase;
            r_len    <= n_len;
            r_flags  <= n_flags;
            r_tokens <= n_tokens;
            r_ref_hi <= n_ref_hi;
        end
    end

    always_comb begin
        ph        = i_sos ? PH_HDR0 : r_phase;
        len       = i_sos ? 24'd0 : r_len;
        tok_dec   = r_tokens - 4'd1;
        ref_cnt   = LZWD_CNT_W'(r_ref_hi[7:4]) + LZWD_CNT_W'(LZWD_MIN_MATCH);
        take      = (len < 24'(ref_cnt)) ? len[LZWD_CNT_W-1:0] : ref_cnt;
        len_after = len;
        tok_done  = 1'b0;
        n_phase   = r_phase;
        n_len     = r_len;
        n_flags   = r_flags;
        n_tokens  = r_tokens;
        n_ref_hi  = r_ref_hi;
        o_push    = 1'b0;
        o_cmd     = '0;
        if (acc) begin
            n_len = len;
            unique case (ph)
                PH_HDR0: begin
                    n_len   = '0;
                    n_phase = PH_HDR1;
                end
                PH_HDR1: begin
                    n_len   = {len[23:8], i_byte};
                    n_phase = PH_HDR2;
                end
                PH_HDR2: begin
                    n_len   = {len[23:16], i_byte, len[7:0]};
                    n_phase = PH_HDR3;
                end
                PH_HDR3: begin
                    n_len   = {i_byte, len[15:0]};
                    n_phase = ({i_byte, len[15:0]} == 24'd0) ? PH_DONE : PH_FLAG;
                end
                PH_FLAG: begin
                    n_flags  = i_byte;
                    n_tokens = 4'(LZWD_GROUP_SIZE);
                    n_phase  = PH_TOKEN;
                end
                PH_TOKEN: begin
                    if (r_flags[7]) begin
                        n_ref_hi = i_byte;
                        n_phase  = PH_REF2;
                    end else begin
                        o_push       = 1'b1;
                        o_cmd.is_lit = 1'b1;
                        o_cmd.lit    = i_byte;
                        o_cmd.cnt    = LZWD_CNT_W'(1);
                        o_cmd.eos    = (len == 24'd1);
                        len_after    = len - 24'd1;
                        tok_done     = 1'b1;
                    end
                end
                PH_REF2: begin
                    o_push       = 1'b1;
                    o_cmd.offset = {1'b0, r_ref_hi[3:0], i_byte} + LZWD_DIST_W'(1);
                    o_cmd.cnt    = take;
                    o_cmd.eos    = (len <= 24'(ref_cnt));
                    len_after    = len - 24'(take);
                    tok_done     = 1'b1;
                end
                PH_DONE: begin
                    n_phase = PH_DONE;
                end
                default: begin
                    n_phase = PH_DONE;
                end
            endcase
            if (tok_done) begin
                n_len    = len_after;
                n_flags  = {r_flags[6:0], 1'b0};
                n_tokens = tok_dec;
                if (len_after == 24'd0) begin
                    n_phase = PH_DONE;
                end else if (tok_dec == 4'd0) begin
                    n_phase = PH_FLAG;
                end else begin
                    n_phase = PH_TOKEN;
                end
            end
        end
    end

endmodule

`default_nettype wire

/* hdl/lz77wd_queue.sv */
// Small job queue between the parser and the copy engine.
// Depends on lz77wd_pkg.
`default_nettype none

module lz77wd_queue (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  lz77wd_pkg::t_cmd       i_cmd,
    output logic                   o_full,
    input  wire logic              i_pop,
    output lz77wd_pkg::t_cmd       o_cmd,
    output logic                   o_empty
);
    import lz77wd_pkg::*;

    localparam int QAW = $clog2(LZWD_QUEUE_DEPTH);

    t_cmd           r_mem [LZWD_QUEUE_DEPTH];
    logic [QAW-1:0] r_wr_ptr;
    logic [QAW-1:0] r_rd_ptr;
    logic [QAW:0]   r_count;
    logic           do_push;
    logic           do_pop;

    assign o_full  = (r_count == (QAW+1)'(LZWD_QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_cmd   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == QAW'(LZWD_QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == QAW'(LZWD_QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            unique case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

/* hdl/lz77wd_back.sv */
// Copy engine: history window, one byte per cycle unless the output stalls, output register.
// Depends on lz77wd_pkg.
`default_nettype none

module lz77wd_back #(
    parameter int WINDOW_DEPTH = lz77wd_pkg::LZWD_WINDOW_DEPTH
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  lz77wd_pkg::t_cmd       i_cmd,
    input  wire logic              i_empty,
    output logic                   o_pop,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output logic [7:0]             o_byte,
    output logic                   o_last,
    output logic                   o_eos
);
    import lz77wd_pkg::*;

    localparam int AW = $clog2(WINDOW_DEPTH);
    localparam int PW = AW + 1;

    logic [7:0]    r_win [WINDOW_DEPTH];

    // active job
    logic          r_act_valid;
    t_cmd          r_act;
    // read stage: byte being fetched from the window
    logic          r_s2_valid;
    logic          r_s2_is_lit;
    logic [7:0]    r_s2_lit;
    logic          r_s2_last;
    logic          r_s2_eos;
    logic [7:0]    r_rd_data;
    logic          r_fwd;
    logic [7:0]    r_fwd_data;
    // output register
    logic          r_out_valid;
    logic [7:0]    r_out_byte;
    logic          r_out_last;
    logic          r_out_eos;
    // window pointers: rd_pos runs one ahead of wr_pos while the read stage is full
    logic [AW-1:0] r_wr_pos;
    logic [AW-1:0] r_rd_pos;

    logic          out_take;
    logic          s2_adv;
    logic          issue;
    logic          act_end;
    logic [7:0]    s2_byte;
    logic [PW-1:0] diff;
    logic [AW-1:0] rd_addr;

    assign out_take = r_out_valid && i_ready;
    assign s2_adv   = r_s2_valid && (!r_out_valid || out_take);
    assign issue    = r_act_valid && (!r_s2_valid || s2_adv);
    assign act_end  = issue && (r_act.cnt == LZWD_CNT_W'(1));
    assign o_pop    = !i_empty && (!r_act_valid || act_end);
    assign s2_byte  = r_s2_is_lit ? r_s2_lit : (r_fwd ? r_fwd_data : r_rd_data);

    assign diff    = {1'b0, r_rd_pos} - PW'(r_act.offset);
    assign rd_addr = diff[PW-1] ? AW'(diff + PW'(WINDOW_DEPTH)) : diff[AW-1:0];

    assign o_valid = r_out_valid;
    assign o_byte  = r_out_byte;
    assign o_last  = r_out_last;
    assign o_eos   = r_out_eos;

    // Byte leaving the read stage is written as the next one is read; a
    // distance of one hits that same slot, so the write data is forwarded.
    always_ff @(posedge i_clk) begin
        if (s2_adv) begin
            r_win[r_wr_pos] <= s2_byte;
        end
        if (issue) begin
            r_rd_data  <= r_win[rd_addr];
            r_fwd      <= s2_adv && (rd_addr == r_wr_pos);
            r_fwd_data <= s2_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_act <= i_cmd;
        end else if (issue) begin
            r_act.cnt <= r_act.cnt - 1'b1;
        end
        if (issue) begin
            r_s2_is_lit <= r_act.is_lit;
            r_s2_lit    <= r_act.lit;
            r_s2_last   <= act_end;
            r_s2_eos    <= act_end && r_act.eos;
        end
        if (s2_adv) begin
            r_out_byte <= s2_byte;
            r_out_last <= r_s2_last;
            r_out_eos  <= r_s2_eos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act_valid <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_wr_pos    <= '0;
            r_rd_pos    <= '0;
        end else begin
            if (o_pop) begin
                r_act_valid <= 1'b1;
            end else if (act_end) begin
                r_act_valid <= 1'b0;
            end
            if (issue) begin
                r_s2_valid <= 1'b1;
                r_rd_pos   <= (r_rd_pos == AW'(WINDOW_DEPTH - 1)) ? '0 : r_rd_pos + 1'b1;
            end else if (s2_adv) begin
                r_s2_valid <= 1'b0;
            end
            if (s2_adv) begin
                r_out_valid <= 1'b1;
                r_wr_pos    <= (r_wr_pos == AW'(WINDOW_DEPTH - 1)) ? '0 : r_wr_pos + 1'b1;
            end else if (out_take) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

/* hdl/lz77_window_decompressor_top.sv */
// Channel   Dir  Beat contents
// s_axis    in   tdata[7:0] compressed byte; tuser start of stream
// m_axis    out  tdata[7:0] output byte; tlast last byte of this input beat;
//                tuser output length reached
//
// Header, flag and reference-head beats are consumed by the parser and make no job.
// A literal or reference beat becomes a job; the copy engine emits its bytes
// at one per cycle, while the output is not stalled, through the window's single
// read port, so a reference yields min(high nibble + 3, bytes still owed) bytes, up to 18.
// The first output byte passes the queue, active job, read stage and output register.
// Reset is synchronous; the window is not cleared and its contents are
// undefined until written. Either side may stall; a 4-job queue decouples them.
// Depends on lz77wd_pkg, lz77wd_front, lz77wd_queue, lz77wd_back.
`default_nettype none

module lz77_window_decompressor_top #(
    parameter int WINDOW_DEPTH = lz77wd_pkg::LZWD_WINDOW_DEPTH
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_s_axis_tvalid,
    output logic            o_s_axis_tready,
    input  wire logic [7:0] i_s_axis_tdata,   // [7:0] in_byte
    input  wire logic       i_s_axis_tuser,   // [0] start_of_stream
    output logic            o_m_axis_tvalid,
    input  wire logic       i_m_axis_tready,
    output logic [7:0]      o_m_axis_tdata,   // [7:0] out_byte
    output logic            o_m_axis_tlast,
    output logic            o_m_axis_tuser    // [0] end_of_stream
);
    import lz77wd_pkg::*;

    logic push;
    t_cmd push_cmd;
    logic q_full;
    logic pop;
    t_cmd pop_cmd;
    logic q_empty;

    lz77wd_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_byte  (i_s_axis_tdata),
        .i_sos   (i_s_axis_tuser),
        .o_push  (push),
        .o_cmd   (push_cmd),
        .i_full  (q_full)
    );

    lz77wd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_cmd   (pop_cmd),
        .o_empty (q_empty)
    );

    lz77wd_back #(
        .WINDOW_DEPTH (WINDOW_DEPTH)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (pop_cmd),
        .i_empty (q_empty),
        .o_pop   (pop),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_byte  (o_m_axis_tdata),
        .o_last  (o_m_axis_tlast),
        .o_eos   (o_m_axis_tuser)
    );

endmodule

`default_nettype wire

/* hdl/lz77wd_checker.sv */
// Port-level checks for the LZ77 window decompressor, bound to the top level.
// Depends on lz77_window_decompressor_top_macros.svh.
`default_nettype none

`include "lz77_window_decompressor_top_macros.svh"

module lz77wd_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_s_axis_tvalid,
    input wire logic       o_s_axis_tready,
    input wire logic [7:0] i_s_axis_tdata,
    input wire logic       i_s_axis_tuser,
    input wire logic       o_m_axis_tvalid,
    input wire logic       i_m_axis_tready,
    input wire logic [7:0] o_m_axis_tdata,
    input wire logic       o_m_axis_tlast,
    input wire logic       o_m_axis_tuser
);

    // a stalled output beat must stay, contents included
    `LZWD_ASSERT(a_out_hold, o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable({o_m_axis_tdata, o_m_axis_tlast, o_m_axis_tuser}), "output beat changed while stalled")

    // stream end is always the final byte of its input beat
    `LZWD_ASSERT(a_eos_last, o_m_axis_tvalid && o_m_axis_tuser |-> o_m_axis_tlast, "end of stream without tlast")

    // an accepted input beat carries known contents
    `LZWD_ASSERT(a_in_known, i_s_axis_tvalid && o_s_axis_tready |-> !$isunknown({i_s_axis_tdata, i_s_axis_tuser}), "unknown input beat accepted")

    // reset empties the output
    `LZWD_ASSERT_ALWAYS(a_rst_empty, !i_rst_n |=> !o_m_axis_tvalid, "output valid right after reset")

endmodule

bind lz77_window_decompressor_top lz77wd_checker u_lz77wd_checker (.*);

`default_nettype wire

/* tb/sv/tb_lz77_window_decompressor_top.sv */
// Self-checking testbench for lz77_window_decompressor_top: directed table, then random streams.
// A local decoder model predicts every output byte; depends on lz77wd_pkg and the RTL.
`timescale 1ns / 100ps

module tb_lz77_window_decompressor_top;

    import lz77wd_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int RAND_BEATS  = 93;
    localparam int DRAIN_WAIT  = 100;
    localparam int MAX_REPORTS = 10;
    localparam int N_DIR       = 27;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       eos;
    } t_lz_out;

    // How a directed row is checked: by the decoder model, no output, or one typed byte
    typedef enum logic [1:0] {
        CHK_MODEL,
        CHK_NONE,
        CHK_ONE
    } t_chk;

    typedef struct packed {
        logic [7:0] data;
        logic       sos;
        t_chk       chk;
        logic [7:0] t_byte;
        logic       t_eos;
    } t_dir_row;

    localparam t_dir_row DIR_TBL [N_DIR] = '{
        // no start flag after reset: taken as the type byte
        '{8'h10, 1'b0, CHK_NONE,  8'h00, 1'b0},
        '{8'h05, 1'b0, CHK_NONE,  8'h00, 1'b0},
        '{8'h00, 1'b0, CHK_NONE,  8'h00, 1'b0},
        '{8'h00, 1'b0, CHK_NONE,  8'h00, 1'b0},
        '{8'h40, 1'b0, CHK_NONE,  8'h00, 1'b0},   // literal, reference, literal
        '{8'hFF, 1'b0, CHK_ONE,   8'hFF, 1'b0},
        '{8'h00, 1'b0, CHK_NONE,  8'h00, 1'b0},   // reference head
        '{8'h00, 1'b0, CHK_MODEL, 8'h00, 1'b0},   // distance 1, copy overlaps itself
        '{8'h00, 1'b0, CHK_ONE,   8'h00, 1'b1},
        '{8'hAA, 1'b0, CHK_NONE,  8'h00, 1'b0},   // after the end: ignored
        // zero length header
        '{8'h10, 1'b1, CHK_NONE,  8'h00, 1'b0},
        '{8'h00, 1'b0, CHK_NONE,  8'h00, 1'b0},
        '{8'h00, 1'b0, CHK_NONE,  8'h00, 1'b0},
        '{8'h00, 1'b0, CHK_NONE,  8'h00, 1'b0},
        // largest length
        '{8'h10, 1'b1, CHK_NONE,  8'h00, 1'b0},
        '{8'hFF, 1'b0, CHK_NONE,  8'h00, 1'b0},
        '{8'hFF, 1'b0, CHK_NONE,  8'h00, 1'b0},
        '{8'hFF, 1'b0, CHK_NONE,  8'h00, 1'b0},
        '{8'h00, 1'b0, CHK_NONE,  8'h00, 1'b0},
        '{8'h00, 1'b0, CHK_ONE,   8'h00, 1'b0},
        // restart mid-stream, length 2, longest match cut short, reads old history
        '{8'h10, 1'b1, CHK_NONE,  8'h00, 1'b0},
        '{8'h02, 1'b0, CHK_NONE,  8'h00, 1'b0},
        '{8'h00, 1'b0, CHK_NONE,  8'h00, 1'b0},
        '{8'h00, 1'b0, CHK_NONE,  8'h00, 1'b0},
        '{8'h80, 1'b0, CHK_NONE,  8'h00, 1'b0},
        '{8'hF0, 1'b0, CHK_NONE,  8'h00, 1'b0},
        '{8'h00, 1'b0, CHK_MODEL, 8'h00, 1'b0}
    };

    logic       i_clk;
    logic       i_rst_n;
    logic       i_s_axis_tvalid;
    logic       o_s_axis_tready;
    logic [7:0] i_s_axis_tdata;
    logic       i_s_axis_tuser;
    logic       o_m_axis_tvalid;
    logic       i_m_axis_tready;
    logic [7:0] o_m_axis_tdata;
    logic       o_m_axis_tlast;
    logic       o_m_axis_tuser;

    lz77_window_decompressor_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),    // [7:0] in_byte
        .i_s_axis_tuser  (i_s_axis_tuser),    // [0] start_of_stream
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),    // [7:0] out_byte
        .o_m_axis_tlast  (o_m_axis_tlast),    // last byte of this input beat
        .o_m_axis_tuser  (o_m_axis_tuser)     // [0] end_of_stream
    );

    // Decoder model state
    t_phase      lz_phase;
    logic [23:0] owed;
    logic [7:0]  flag_sr;
    logic [3:0]  tokens_left;
    logic [7:0]  ref_head;
    logic [7:0]  hist [LZWD_WINDOW_DEPTH];
    logic [11:0] hist_wr;
    int          hist_fill;      // bytes written since reset, saturating

    t_lz_out     step_out [18];
    int          step_n;
    t_lz_out     exp_bytes [$];

    int          n_beats;
    int          n_streams;
    int          n_checked;
    int          n_bad;
    bit          tx_calm;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(11, 30);
    endfunction

    task automatic emit_byte(input logic [7:0] v);
        hist[hist_wr] = v;
        hist_wr       = hist_wr + 12'd1;
        if (hist_fill < LZWD_WINDOW_DEPTH)
            hist_fill++;
        owed = owed - 24'd1;
        step_out[step_n] = t_lz_out'{v, 1'b0, (owed == 24'd0)};
        step_n++;
    endtask

    task automatic next_token_slot();
        flag_sr     = flag_sr << 1;
        tokens_left = tokens_left - 4'd1;
        if (owed == 24'd0)
            lz_phase = PH_DONE;
        else if (tokens_left == 4'd0)
            lz_phase = PH_FLAG;
        else
            lz_phase = PH_TOKEN;
    endtask

    // One input beat through the decoder model; results land in step_out
    task automatic lz_predict(input logic [7:0] b, input logic sos);
        logic [12:0] ref_off;
        logic [4:0]  cnt;
        logic [11:0] rd;
        int          j;
        step_n = 0;
        if (sos) begin
            lz_phase = PH_HDR0;
            owed     = 24'd0;
        end
        case (lz_phase)
            PH_HDR0: begin
                owed     = 24'd0;
                lz_phase = PH_HDR1;
            end
            PH_HDR1: begin
                owed     = owed | {16'd0, b};
                lz_phase = PH_HDR2;
            end
            PH_HDR2: begin
                owed     = owed | {8'd0, b, 8'd0};
                lz_phase = PH_HDR3;
            end
            PH_HDR3: begin
                owed     = owed | {b, 16'd0};
                lz_phase = (owed == 24'd0) ? PH_DONE : PH_FLAG;
            end
            PH_FLAG: begin
                flag_sr     = b;
                tokens_left = 4'd8;
                lz_phase    = PH_TOKEN;
            end
            PH_TOKEN: begin
                if (flag_sr[7]) begin
                    ref_head = b;
                    lz_phase = PH_REF2;
                end else begin
                    emit_byte(b);
                    next_token_slot();
                end
            end
            PH_REF2: begin
                ref_off = {1'b0, ref_head[3:0], b} + 13'd1;
                cnt     = {1'b0, ref_head[7:4]} + 5'd3;
                for (j = 0; j < cnt && owed != 24'd0; j++) begin
                    rd = hist_wr - ref_off[11:0];   // distance 4096 wraps onto the write slot
                    emit_byte(hist[rd]);
                end
                next_token_slot();
            end
            default: ;
        endcase
        if (step_n > 0)
            step_out[step_n-1].last = 1'b1;
    endtask

    task automatic feed_byte(input logic [7:0] b, input logic sos, input t_chk chk,
                             input logic [7:0] t_byte, input logic t_eos);
        int gap;
        int k;
        lz_predict(b, sos);
        case (chk)
            CHK_MODEL: begin
                for (k = 0; k < step_n; k++)
                    exp_bytes.push_back(step_out[k]);
            end
            CHK_ONE: exp_bytes.push_back(t_lz_out'{t_byte, 1'b1, t_eos});
            default: ;
        endcase
        gap = tx_calm ? 0 : pick_gap();
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= b;
        i_s_axis_tuser  <= sos;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        n_beats++;
    endtask

    // Next byte of a well-formed stream; references never reach unwritten history
    function automatic logic [7:0] next_stream_byte(input bit heavy);
        logic [7:0] b;
        int         lim;
        int         lo;
        b = 8'($urandom_range(0, 255));
        case (lz_phase)
            PH_HDR1: b = 8'($urandom_range(0, 60));
            PH_HDR2: b = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255)) : 8'h00;
            PH_HDR3: b = 8'h00;
            PH_FLAG: begin
                if (heavy)
                    b = 8'hFF;
                if (hist_fill == 0)
                    b[7] = 1'b0;
            end
            PH_TOKEN: begin
                if (flag_sr[7]) begin
                    lim = (hist_fill >= LZWD_WINDOW_DEPTH) ? 15 : (hist_fill - 1) / 256;
                    lo  = $urandom_range(0, 1) ? 0 : $urandom_range(0, lim);
                    b[3:0] = 4'(lo);
                    if (heavy)
                        b[7:4] = 4'hF;
                end
            end
            PH_REF2: begin
                lim = ((hist_fill >= LZWD_WINDOW_DEPTH) ? 4095 : hist_fill - 1)
                      - int'(ref_head[3:0]) * 256;
                if (lim > 255)
                    lim = 255;
                case ($urandom_range(0, 7))
                    0:       b = 8'(lim);
                    1, 2:    b = 8'($urandom_range(0, (lim < 7) ? lim : 7));
                    default: b = 8'($urandom_range(0, lim));
                endcase
            end
            default: ;
        endcase
        return b;
    endfunction

    task automatic feed_stream(input logic [23:0] len, input bit heavy, input int cap);
        int         beats;
        logic [7:0] b;
        n_streams++;
        tx_calm = ($urandom_range(0, 4) == 0);
        feed_byte(8'($urandom_range(0, 255)), 1'b1, CHK_MODEL, 8'h00, 1'b0);
        feed_byte(len[7:0],   1'b0, CHK_MODEL, 8'h00, 1'b0);
        feed_byte(len[15:8],  1'b0, CHK_MODEL, 8'h00, 1'b0);
        feed_byte(len[23:16], 1'b0, CHK_MODEL, 8'h00, 1'b0);
        beats = 4;
        while (lz_phase != PH_DONE && beats < cap) begin
            if (!heavy && $urandom_range(0, 99) < 3)
                feed_byte(8'($urandom_range(0, 255)), 1'b1, CHK_MODEL, 8'h00, 1'b0);  // restart
            else begin
                b = next_stream_byte(heavy);
                feed_byte(b, 1'b0, CHK_MODEL, 8'h00, 1'b0);
            end
            beats++;
        end
        // trailing junk after the end is dropped by the block
        if (lz_phase == PH_DONE && $urandom_range(0, 9) < 3)
            repeat ($urandom_range(1, 3))
                feed_byte(8'($urandom_range(0, 255)), 1'b0, CHK_MODEL, 8'h00, 1'b0);
    endtask

    initial begin : rx_side
        int      stall;
        bit      calm;
        t_lz_out got;
        t_lz_out want;
        stall = 0;
        calm  = 1'b0;
        i_m_axis_tready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
                got = t_lz_out'{o_m_axis_tdata, o_m_axis_tlast, o_m_axis_tuser};
                if (exp_bytes.size() == 0) begin
                    n_bad++;
                    if (n_bad <= MAX_REPORTS)
                        $display("%0t: unexpected output beat data=%02h last=%0b eos=%0b",
                                 $realtime, got.data, got.last, got.eos);
                end else begin
                    want = exp_bytes.pop_front();
                    n_checked++;
                    if (got !== want) begin
                        n_bad++;
                        if (n_bad <= MAX_REPORTS)
                            $display("%0t: byte %0d exp data=%02h last=%0b eos=%0b, got data=%02h last=%0b eos=%0b",
                                     $realtime, n_checked, want.data, want.last, want.eos,
                                     got.data, got.last, got.eos);
                    end
                end
            end
            if ($urandom_range(0, 299) == 0)
                calm = !calm;
            if (stall > 0)
                stall--;
            else if (!calm && $urandom_range(0, 2) == 0)
                stall = pick_gap();
            i_m_axis_tready <= (stall == 0);
        end
    end

    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("timeout after %0d cycles, %0d bytes still expected", cycles, exp_bytes.size());
        $display("** lz77_window_decompressor_top: FAILED **");
        $finish;
    end

    initial begin : stimulus
        int         r;
        int         start;
        int         room;
        int         guard;
        int         leftover;
        logic [23:0] len;
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = 8'h00;
        i_s_axis_tuser  = 1'b0;
        lz_phase    = PH_HDR0;
        owed        = 24'd0;
        flag_sr     = 8'h00;
        tokens_left = 4'd0;
        ref_head    = 8'h00;
        hist_wr     = 12'd0;
        hist_fill   = 0;
        n_beats     = 0;
        n_streams   = 4;
        n_checked   = 0;
        n_bad       = 0;
        tx_calm     = 1'b0;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < N_DIR; i++)
            feed_byte(DIR_TBL[i].data, DIR_TBL[i].sos, DIR_TBL[i].chk,
                      DIR_TBL[i].t_byte, DIR_TBL[i].t_eos);

        start = n_beats;
        while (n_beats - start < RAND_BEATS) begin
            room = RAND_BEATS - (n_beats - start);
            r = $urandom_range(0, 99);
            if (r < 8)
                len = 24'd0;
            else if (r < 70)
                len = 24'($urandom_range(1, 40));
            else if (r < 92)
                len = 24'($urandom_range(41, 150));
            else
                len = 24'($urandom);
            feed_stream(len, ($urandom_range(0, 4) == 0), (room < 36) ? room + 4 : 40);
        end
        i_s_axis_tvalid <= 1'b0;

        guard = 0;
        while (exp_bytes.size() != 0 && guard < 50_000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (DRAIN_WAIT) @(posedge i_clk);
        leftover = exp_bytes.size();
        if (leftover != 0)
            $display("%0d expected output bytes never arrived", leftover);

        $display("Ran %0d input beats over %0d streams; %0d output bytes checked, %0d errors.",
                 n_beats, n_streams, n_checked, n_bad + leftover);
        $display("Literals, overlapping and cut-short matches, restarts, zero-length streams and back-references.");
        if (n_bad == 0 && leftover == 0)
            $display("** lz77_window_decompressor_top: PASSED **");
        else
            $display("** lz77_window_decompressor_top: FAILED **");
        $finish;
    end

endmodule
